// ===== rtl/cist_pkg.sv =====
// Shared types and constants for the compacting integer set table.
package cist_pkg;

    localparam int CAPACITY  = 16;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 5;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } cist_state_t;

    // Broadcast to every cell during the execute cycle.
    typedef struct packed
    {
        logic              exec;
        logic              is_insert;
        logic              is_remove;
        logic [VAL_W-1:0]  value;
    } cell_ctl_t;

endpackage

// ===== rtl/cist_cell.sv =====
// One table cell: holds one entry, compares, passes the hit chain and shifts down.
module cist_cell import cist_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic             occ,
    input  logic             tail,
    input  logic             found,
    input  logic             hit_in,
    input  logic [VAL_W-1:0] entry_up,
    output logic             hit_out,
    output logic [VAL_W-1:0] entry
);

    logic [VAL_W-1:0] entry_reg;
    logic [VAL_W-1:0] entry_next;
    logic             match;

    assign match   = occ && (entry_reg == ctl.value);
    assign hit_out = hit_in | match;
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.exec && ctl.is_remove && hit_out && occ)
        begin
            // matched here or below: take the neighbor's entry
            entry_next = entry_up;
        end
        else if (ctl.exec && ctl.is_insert && tail && !found)
        begin
            entry_next = ctl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/compacting_integer_set_table.sv =====
// Top level of the compacting integer set table: control, count and the cell row.
//
// Usage:
//   Command channel: drive opcode (lookup, insert, remove; the unused code acts
//   as a lookup) and value, and raise start. The beat is taken on the rising
//   edge where start is high and busy is low.
//   Result channel: done pulses high for one cycle with was_present, status,
//   member_count and is_empty. The receiver cannot stall; the result must be
//   captured in that cycle.
// Timing:
//   The accepting edge latches the command. The execute cycle broadcasts the
//   value to a row of CAPACITY cells; each compares its entry and passes a hit
//   bit to its upper neighbor, so every cell at or above the match knows to
//   shift down on a remove, and the cell at the tail takes the value on an
//   insert. The row and count update at the end of the execute cycle and
//   done is registered from exec; busy is high during the execute cycle.
//   The hit chain through the cell row sets the execute cycle's path length.
// Reset:
//   rst_n clears the count and control; entries are undefined and never read
//   beyond the count. An insert into a full table is refused with status 1.
module compacting_integer_set_table import cist_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            opcode,
    input  logic signed [31:0]    value,
    output logic                  busy,
    output logic                  done,
    output logic                  was_present,
    output logic                  status,
    output logic [OUT_CNT_W-1:0]  member_count,
    output logic                  is_empty
);

    cist_state_t      state_reg;
    cist_state_t      state_next;
    logic [1:0]       op_reg;
    logic [VAL_W-1:0] value_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             present_reg;
    logic             status_reg;
    logic             status_next;
    logic             accept;
    logic             exec;
    logic             full;
    logic             present;
    cell_ctl_t        ctl;

    logic [CAPACITY:0]              hit;
    logic [CAPACITY-1:0][VAL_W-1:0] entry;

    assign accept = start && !busy;
    assign exec   = (state_reg == ST_EXEC);
    assign full   = (count_reg == CNT_W'(CAPACITY));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: busy = 1'b0;
            ST_EXEC: busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            value_reg <= value;
        end
        if (exec)
        begin
            present_reg <= present;
            status_reg  <= status_next;
        end
    end

    // broadcast to the cell row
    always_comb
    begin
        ctl.exec      = exec;
        ctl.is_insert = (op_reg == OP_INSERT);
        ctl.is_remove = (op_reg == OP_REMOVE);
        ctl.value     = value_reg;
    end

    assign hit[0]  = 1'b0;
    assign present = hit[CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] up;
        if (i == CAPACITY - 1)
        begin : g_top
            assign up = entry[i];
        end
        else
        begin : g_mid
            assign up = entry[i+1];
        end

        cist_cell u_cell
        (
            .clk      (clk),
            .ctl      (ctl),
            .occ      (count_reg > CNT_W'(i)),
            .tail     (count_reg == CNT_W'(i)),
            .found    (present),
            .hit_in   (hit[i]),
            .entry_up (up),
            .hit_out  (hit[i+1]),
            .entry    (entry[i])
        );
    end

    // count and status
    always_comb
    begin
        count_next  = count_reg;
        status_next = 1'b0;
        if (exec)
        begin
            if (ctl.is_insert && !present)
            begin
                if (full)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else if (ctl.is_remove && present)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    assign done         = done_reg;
    assign was_present  = present_reg;
    assign status       = status_reg;
    assign member_count = OUT_CNT_W'(count_reg);
    assign is_empty     = (count_reg == '0);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("result strobe without execute cycle");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("insert refused while table not full");

    a_count_moves_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg == ST_EXEC))
        else $error("count changed outside execute cycle");

    a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> !exec)
        else $error("back-to-back execute cycles");
`endif

endmodule
